/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CJ_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CJ_IMPLY_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cj_pkg.sv */
package cj_pkg;

    localparam int CW        = 32;
    localparam int FRAC_BITS = 16;
    // Coordinate differences and their magnitudes.
    localparam int MW  = CW + 1;
    // Multiplier operand chunk.
    localparam int K   = MW + 1;
    localparam int PW  = 2 * MW;
    localparam int NMW = 3 * MW;
    localparam int NSW = NMW + 2;
    localparam int PNW = 4 * MW;
    localparam int C2W = 4 * MW;
    localparam int NW  = PNW + FRAC_BITS + 1;
    localparam int D2W = C2W + 1;
    localparam int QW  = CW + 1;
    localparam int RW  = NW + QW;
    localparam int NE  = 4;

    localparam logic [QW-1:0] LIM_Q = {2'b01, {(CW-1){1'b0}}};

    typedef struct packed {
        logic valid;
        logic degen;
    } t_tag;

    typedef logic signed [MW-1:0] t_diff;

    function automatic logic [2*K-1:0] mul_k(input logic [K-1:0] a, input logic [K-1:0] b);
        return {{K{1'b0}}, a} * {{K{1'b0}}, b};
    endfunction

    function automatic logic [MW-1:0] mag_d(input logic signed [MW-1:0] a);
        logic [MW-1:0] t;
        t = a;
        return a[MW-1] ? (~t + 1'b1) : t;
    endfunction

    function automatic logic signed [MW-1:0] sext_d(input logic signed [CW-1:0] a);
        return $signed({a[CW-1], a});
    endfunction

endpackage

/* rtl/cj_front.sv */
module cj_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  cj_pkg::t_tag                      i_tag,
    input  logic signed [cj_pkg::CW-1:0]      i_ri_x,
    input  logic signed [cj_pkg::CW-1:0]      i_ri_y,
    input  logic signed [cj_pkg::CW-1:0]      i_rj_x,
    input  logic signed [cj_pkg::CW-1:0]      i_rj_y,
    input  logic signed [cj_pkg::CW-1:0]      i_rk_x,
    input  logic signed [cj_pkg::CW-1:0]      i_rk_y,
    output cj_pkg::t_tag                      o_tag,
    output logic signed [cj_pkg::NSW-1:0]     o_nx,
    output logic signed [cj_pkg::NSW-1:0]     o_ny,
    output logic [cj_pkg::C2W-1:0]            o_c2,
    output logic [cj_pkg::MW-1:0]             o_pm0,
    output logic [cj_pkg::MW-1:0]             o_pm1,
    output logic                              o_ps0,
    output logic                              o_ps1
);

    localparam int MW  = cj_pkg::MW;
    localparam int K   = cj_pkg::K;
    localparam int PW  = cj_pkg::PW;
    localparam int NMW = cj_pkg::NMW;
    localparam int NSW = cj_pkg::NSW;
    localparam int C2W = cj_pkg::C2W;

    // Stage 1: differences u = rj - ri, v = rk - ri, b = rj - rk.
    cj_pkg::t_tag  r1_tag;
    cj_pkg::t_diff r1_ux, r1_uy, r1_vx, r1_vy, r1_bx, r1_by;
    cj_pkg::t_diff n1_ux, n1_uy, n1_vx, n1_vy, n1_bx, n1_by;

    always_comb begin
        n1_ux = cj_pkg::sext_d(i_rj_x) - cj_pkg::sext_d(i_ri_x);
        n1_uy = cj_pkg::sext_d(i_rj_y) - cj_pkg::sext_d(i_ri_y);
        n1_vx = cj_pkg::sext_d(i_rk_x) - cj_pkg::sext_d(i_ri_x);
        n1_vy = cj_pkg::sext_d(i_rk_y) - cj_pkg::sext_d(i_ri_y);
        n1_bx = cj_pkg::sext_d(i_rj_x) - cj_pkg::sext_d(i_rk_x);
        n1_by = cj_pkg::sext_d(i_rj_y) - cj_pkg::sext_d(i_rk_y);
    end

    // Stage 2: the six 2-by-2 products as magnitudes.
    cj_pkg::t_tag  r2_tag;
    logic [PW-1:0] r2_a, r2_b, r2_uxx, r2_uyy, r2_vxx, r2_vyy;
    logic          r2_na, r2_nb;
    cj_pkg::t_diff r2_ux, r2_uy, r2_vx, r2_vy, r2_bx, r2_by;
    logic [2*K-1:0] p2_a, p2_b, p2_uxx, p2_uyy, p2_vxx, p2_vyy;

    always_comb begin
        logic [K-1:0] m_ux, m_uy, m_vx, m_vy;
        m_ux = {1'b0, cj_pkg::mag_d(r1_ux)};
        m_uy = {1'b0, cj_pkg::mag_d(r1_uy)};
        m_vx = {1'b0, cj_pkg::mag_d(r1_vx)};
        m_vy = {1'b0, cj_pkg::mag_d(r1_vy)};
        p2_a   = cj_pkg::mul_k(m_ux, m_vy);
        p2_b   = cj_pkg::mul_k(m_uy, m_vx);
        p2_uxx = cj_pkg::mul_k(m_ux, m_ux);
        p2_uyy = cj_pkg::mul_k(m_uy, m_uy);
        p2_vxx = cj_pkg::mul_k(m_vx, m_vx);
        p2_vyy = cj_pkg::mul_k(m_vy, m_vy);
    end

    // Stage 3: C = cross(u, v), |u|^2 and |v|^2.
    cj_pkg::t_tag  r3_tag;
    logic [PW-1:0] r3_cmag, r3_u2, r3_v2;
    cj_pkg::t_diff r3_ux, r3_uy, r3_vx, r3_vy, r3_bx, r3_by;
    logic [PW-1:0] n3_cmag;
    logic          n3_degen;

    always_comb begin
        logic signed [PW+1:0] sa, sb, c;
        logic [PW+1:0]        cm;
        sa = $signed({2'b00, r2_a});
        sb = $signed({2'b00, r2_b});
        if (r2_na) begin
            sa = -sa;
        end
        if (r2_nb) begin
            sb = -sb;
        end
        c        = sa - sb;
        cm       = c[PW+1] ? (~c + 1'b1) : c;
        n3_cmag  = cm[PW-1:0];
        n3_degen = (c == '0);
    end

    // Stage 4: partial products of n and of C^2, operands cut into K-bit chunks.
    cj_pkg::t_tag   r4_tag;
    logic [2*K-1:0] r4_np [8];
    logic [2*K-1:0] r4_cp [4];
    logic [3:0]     r4_sn;
    logic [MW-1:0]  r4_pm0, r4_pm1;
    logic           r4_ps0, r4_ps1;
    logic [2*K-1:0] n4_np [8];
    logic [2*K-1:0] n4_cp [4];

    always_comb begin
        logic [K-1:0] u2_lo, u2_hi, v2_lo, v2_hi, c_lo, c_hi;
        logic [K-1:0] m_ux, m_uy, m_vx, m_vy;
        u2_lo = r3_u2[K-1:0];
        u2_hi = {{(2*K-PW){1'b0}}, r3_u2[PW-1:K]};
        v2_lo = r3_v2[K-1:0];
        v2_hi = {{(2*K-PW){1'b0}}, r3_v2[PW-1:K]};
        c_lo  = r3_cmag[K-1:0];
        c_hi  = {{(2*K-PW){1'b0}}, r3_cmag[PW-1:K]};
        m_ux  = {1'b0, cj_pkg::mag_d(r3_ux)};
        m_uy  = {1'b0, cj_pkg::mag_d(r3_uy)};
        m_vx  = {1'b0, cj_pkg::mag_d(r3_vx)};
        m_vy  = {1'b0, cj_pkg::mag_d(r3_vy)};
        n4_np[0] = cj_pkg::mul_k(m_vy, u2_lo);
        n4_np[1] = cj_pkg::mul_k(m_vy, u2_hi);
        n4_np[2] = cj_pkg::mul_k(m_uy, v2_lo);
        n4_np[3] = cj_pkg::mul_k(m_uy, v2_hi);
        n4_np[4] = cj_pkg::mul_k(m_ux, v2_lo);
        n4_np[5] = cj_pkg::mul_k(m_ux, v2_hi);
        n4_np[6] = cj_pkg::mul_k(m_vx, u2_lo);
        n4_np[7] = cj_pkg::mul_k(m_vx, u2_hi);
        n4_cp[0] = cj_pkg::mul_k(c_lo, c_lo);
        n4_cp[1] = cj_pkg::mul_k(c_lo, c_hi);
        n4_cp[2] = cj_pkg::mul_k(c_hi, c_lo);
        n4_cp[3] = cj_pkg::mul_k(c_hi, c_hi);
    end

    // Stage 5: the four terms of n and C^2 assembled.
    cj_pkg::t_tag   r5_tag;
    logic [NMW-1:0] r5_t [4];
    logic [3:0]     r5_sn;
    logic [C2W-1:0] r5_c2;
    logic [MW-1:0]  r5_pm0, r5_pm1;
    logic           r5_ps0, r5_ps1;
    logic [NMW-1:0] n5_t [4];
    logic [C2W-1:0] n5_c2;

    always_comb begin
        logic [C2W-1:0] mid;
        n5_t[0] = {{(NMW-2*K){1'b0}}, r4_np[0]} + ({{(NMW-2*K){1'b0}}, r4_np[1]} << K);
        n5_t[1] = {{(NMW-2*K){1'b0}}, r4_np[2]} + ({{(NMW-2*K){1'b0}}, r4_np[3]} << K);
        n5_t[2] = {{(NMW-2*K){1'b0}}, r4_np[4]} + ({{(NMW-2*K){1'b0}}, r4_np[5]} << K);
        n5_t[3] = {{(NMW-2*K){1'b0}}, r4_np[6]} + ({{(NMW-2*K){1'b0}}, r4_np[7]} << K);
        mid     = {{(C2W-2*K){1'b0}}, r4_cp[1]} + {{(C2W-2*K){1'b0}}, r4_cp[2]};
        n5_c2   = {{(C2W-2*K){1'b0}}, r4_cp[0]} + (mid << K)
                + ({{(C2W-2*K){1'b0}}, r4_cp[3]} << (2*K));
    end

    // Stage 6: signed n = (vy|u|^2 - uy|v|^2, ux|v|^2 - vx|u|^2).
    cj_pkg::t_tag          r6_tag;
    logic signed [NSW-1:0] r6_nx, r6_ny;
    logic [C2W-1:0]        r6_c2;
    logic [MW-1:0]         r6_pm0, r6_pm1;
    logic                  r6_ps0, r6_ps1;
    logic signed [NSW-1:0] n6_nx, n6_ny;

    always_comb begin
        logic signed [NSW-1:0] s0, s1, s2, s3;
        s0 = $signed({2'b00, r5_t[0]});
        s1 = $signed({2'b00, r5_t[1]});
        s2 = $signed({2'b00, r5_t[2]});
        s3 = $signed({2'b00, r5_t[3]});
        if (r5_sn[0]) begin
            s0 = -s0;
        end
        if (r5_sn[1]) begin
            s1 = -s1;
        end
        if (r5_sn[2]) begin
            s2 = -s2;
        end
        if (r5_sn[3]) begin
            s3 = -s3;
        end
        n6_nx = s0 - s1;
        n6_ny = s2 - s3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            r3_tag <= '0;
            r4_tag <= '0;
            r5_tag <= '0;
            r6_tag <= '0;
        end else if (i_en) begin
            r1_tag <= i_tag;
            r2_tag <= r1_tag;
            r3_tag <= '{valid: r2_tag.valid, degen: n3_degen};
            r4_tag <= r3_tag;
            r5_tag <= r4_tag;
            r6_tag <= r5_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ux <= n1_ux;
            r1_uy <= n1_uy;
            r1_vx <= n1_vx;
            r1_vy <= n1_vy;
            r1_bx <= n1_bx;
            r1_by <= n1_by;

            r2_a   <= p2_a[PW-1:0];
            r2_b   <= p2_b[PW-1:0];
            r2_uxx <= p2_uxx[PW-1:0];
            r2_uyy <= p2_uyy[PW-1:0];
            r2_vxx <= p2_vxx[PW-1:0];
            r2_vyy <= p2_vyy[PW-1:0];
            r2_na  <= r1_ux[MW-1] ^ r1_vy[MW-1];
            r2_nb  <= r1_uy[MW-1] ^ r1_vx[MW-1];
            r2_ux  <= r1_ux;
            r2_uy  <= r1_uy;
            r2_vx  <= r1_vx;
            r2_vy  <= r1_vy;
            r2_bx  <= r1_bx;
            r2_by  <= r1_by;

            r3_cmag <= n3_cmag;
            r3_u2   <= r2_uxx + r2_uyy;
            r3_v2   <= r2_vxx + r2_vyy;
            r3_ux   <= r2_ux;
            r3_uy   <= r2_uy;
            r3_vx   <= r2_vx;
            r3_vy   <= r2_vy;
            r3_bx   <= r2_bx;
            r3_by   <= r2_by;

            r4_np  <= n4_np;
            r4_cp  <= n4_cp;
            r4_sn  <= {r3_vx[MW-1], r3_ux[MW-1], r3_uy[MW-1], r3_vy[MW-1]};
            r4_pm0 <= cj_pkg::mag_d(r3_by);
            r4_pm1 <= cj_pkg::mag_d(r3_bx);
            r4_ps0 <= r3_by[MW-1];
            // The y row uses -bx, negative when bx is positive.
            r4_ps1 <= ~r3_bx[MW-1];

            r5_t   <= n5_t;
            r5_sn  <= r4_sn;
            r5_c2  <= n5_c2;
            r5_pm0 <= r4_pm0;
            r5_pm1 <= r4_pm1;
            r5_ps0 <= r4_ps0;
            r5_ps1 <= r4_ps1;

            r6_nx  <= n6_nx;
            r6_ny  <= n6_ny;
            r6_c2  <= r5_c2;
            r6_pm0 <= r5_pm0;
            r6_pm1 <= r5_pm1;
            r6_ps0 <= r5_ps0;
            r6_ps1 <= r5_ps1;
        end
    end

    assign o_tag = r6_tag;
    assign o_nx  = r6_nx;
    assign o_ny  = r6_ny;
    assign o_c2  = r6_c2;
    assign o_pm0 = r6_pm0;
    assign o_pm1 = r6_pm1;
    assign o_ps0 = r6_ps0;
    assign o_ps1 = r6_ps1;

endmodule

/* rtl/cj_prod.sv */
module cj_prod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  cj_pkg::t_tag                  i_tag,
    input  logic signed [cj_pkg::NSW-1:0] i_nx,
    input  logic signed [cj_pkg::NSW-1:0] i_ny,
    input  logic [cj_pkg::C2W-1:0]        i_c2,
    input  logic [cj_pkg::MW-1:0]         i_pm0,
    input  logic [cj_pkg::MW-1:0]         i_pm1,
    input  logic                          i_ps0,
    input  logic                          i_ps1,
    output cj_pkg::t_tag                  o_tag,
    output logic [cj_pkg::NW-1:0]         o_num [cj_pkg::NE],
    output logic [cj_pkg::D2W-1:0]        o_d2,
    output logic [cj_pkg::NE-1:0]         o_neg
);

    localparam int K   = cj_pkg::K;
    localparam int NMW = cj_pkg::NMW;
    localparam int NSW = cj_pkg::NSW;
    localparam int PNW = cj_pkg::PNW;
    localparam int C2W = cj_pkg::C2W;
    localparam int NW  = cj_pkg::NW;
    localparam int NE  = cj_pkg::NE;
    localparam int F   = cj_pkg::FRAC_BITS;

    // Stage 1: |p| times three chunks of |n| for each of the four entries.
    // Entries are ordered (p.x, n.x), (p.y, n.x), (p.x, n.y), (p.y, n.y).
    cj_pkg::t_tag   r1_tag;
    logic [2*K-1:0] r1_pp [NE][3];
    logic [NE-1:0]  r1_neg;
    logic [C2W-1:0] r1_c2;
    logic [2*K-1:0] n1_pp [NE][3];
    logic [NE-1:0]  n1_neg;

    always_comb begin
        logic [NSW-1:0] ax, ay;
        logic [K-1:0]   chx [3];
        logic [K-1:0]   chy [3];
        logic [K-1:0]   pm;
        logic           ps, ns;
        ax = i_nx[NSW-1] ? (~i_nx + 1'b1) : i_nx;
        ay = i_ny[NSW-1] ? (~i_ny + 1'b1) : i_ny;
        chx[0] = ax[K-1:0];
        chx[1] = ax[2*K-1:K];
        chx[2] = {{(3*K-NMW){1'b0}}, ax[NMW-1:2*K]};
        chy[0] = ay[K-1:0];
        chy[1] = ay[2*K-1:K];
        chy[2] = {{(3*K-NMW){1'b0}}, ay[NMW-1:2*K]};
        for (int e = 0; e < NE; e++) begin
            if (e == 1 || e == 3) begin
                pm = {1'b0, i_pm1};
                ps = i_ps1;
            end else begin
                pm = {1'b0, i_pm0};
                ps = i_ps0;
            end
            for (int j = 0; j < 3; j++) begin
                n1_pp[e][j] = cj_pkg::mul_k(pm, (e < 2) ? chx[j] : chy[j]);
            end
            ns = (e < 2) ? i_nx[NSW-1] : i_ny[NSW-1];
            // The entry is -p*n/(2C^2): negative when p*n is positive.
            n1_neg[e] = ~(ps ^ ns);
        end
    end

    // Stage 2: |p*n| assembled.
    cj_pkg::t_tag   r2_tag;
    logic [PNW-1:0] r2_pn [NE];
    logic [NE-1:0]  r2_neg;
    logic [C2W-1:0] r2_c2;
    logic [PNW-1:0] n2_pn [NE];

    always_comb begin
        for (int e = 0; e < NE; e++) begin
            n2_pn[e] = {{(PNW-2*K){1'b0}}, r1_pp[e][0]}
                     + ({{(PNW-2*K){1'b0}}, r1_pp[e][1]} << K)
                     + ({{(PNW-2*K){1'b0}}, r1_pp[e][2]} << (2*K));
        end
    end

    // Stage 3: numerator |p*n| * 2^F + C^2, rounding half away from zero
    // once divided by 2*C^2.
    cj_pkg::t_tag            r3_tag;
    logic [NW-1:0]           r3_num [NE];
    logic [cj_pkg::D2W-1:0]  r3_d2;
    logic [NE-1:0]           r3_neg;
    logic [NW-1:0]           n3_num [NE];

    always_comb begin
        for (int e = 0; e < NE; e++) begin
            n3_num[e] = {1'b0, r2_pn[e], {F{1'b0}}} + {{(NW-C2W){1'b0}}, r2_c2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            r3_tag <= '0;
        end else if (i_en) begin
            r1_tag <= i_tag;
            r2_tag <= r1_tag;
            r3_tag <= r2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pp  <= n1_pp;
            r1_neg <= n1_neg;
            r1_c2  <= i_c2;
            r2_pn  <= n2_pn;
            r2_neg <= r1_neg;
            r2_c2  <= r1_c2;
            r3_num <= n3_num;
            r3_d2  <= {r2_c2, 1'b0};
            r3_neg <= r2_neg;
        end
    end

    assign o_tag = r3_tag;
    assign o_num = r3_num;
    assign o_d2  = r3_d2;
    assign o_neg = r3_neg;

endmodule

/* rtl/cj_div.sv */
module cj_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  cj_pkg::t_tag           i_tag,
    input  logic [cj_pkg::NW-1:0]  i_num [cj_pkg::NE],
    input  logic [cj_pkg::D2W-1:0] i_d2,
    input  logic [cj_pkg::NE-1:0]  i_neg,
    output cj_pkg::t_tag           o_tag,
    output logic [cj_pkg::QW-1:0]  o_q [cj_pkg::NE],
    output logic [cj_pkg::NE-1:0]  o_ovf,
    output logic [cj_pkg::NE-1:0]  o_neg
);

    localparam int NW  = cj_pkg::NW;
    localparam int D2W = cj_pkg::D2W;
    localparam int QW  = cj_pkg::QW;
    localparam int RW  = cj_pkg::RW;
    localparam int NE  = cj_pkg::NE;

    // Stage 0 checks whether the quotient needs more than QW bits. Stage s
    // then settles quotient bit QW-s by one restoring compare and subtract.
    cj_pkg::t_tag   r_tag [QW+1];
    logic [RW-1:0]  r_rem [QW+1][NE];
    logic [QW-1:0]  r_q   [QW+1][NE];
    logic [D2W-1:0] r_d2  [QW+1];
    logic [NE-1:0]  r_ovf [QW+1];
    logic [NE-1:0]  r_neg [QW+1];

    logic [RW-1:0]  n_rem [QW+1][NE];
    logic [QW-1:0]  n_q   [QW+1][NE];
    logic [NE-1:0]  n_ovf0;

    always_comb begin
        logic [RW-1:0] dx;
        logic [RW-1:0] sh;
        logic          ge;
        dx = {{(RW-D2W){1'b0}}, i_d2} << QW;
        for (int e = 0; e < NE; e++) begin
            n_rem[0][e] = {{(RW-NW){1'b0}}, i_num[e]};
            n_q[0][e]   = '0;
            n_ovf0[e]   = (n_rem[0][e] >= dx);
        end
        for (int s = 0; s < QW; s++) begin
            for (int e = 0; e < NE; e++) begin
                sh = {{(RW-D2W){1'b0}}, r_d2[s]} << (QW - 1 - s);
                ge = (r_rem[s][e] >= sh);
                n_rem[s+1][e] = ge ? (r_rem[s][e] - sh) : r_rem[s][e];
                n_q[s+1][e]   = r_q[s][e];
                n_q[s+1][e][QW-1-s] = ge;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QW; s++) begin
                r_tag[s] <= '0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            for (int s = 0; s < QW; s++) begin
                r_tag[s+1] <= r_tag[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_q[0]   <= n_q[0];
            r_d2[0]  <= i_d2;
            r_ovf[0] <= n_ovf0;
            r_neg[0] <= i_neg;
            for (int s = 0; s < QW; s++) begin
                r_rem[s+1] <= n_rem[s+1];
                r_q[s+1]   <= n_q[s+1];
                r_d2[s+1]  <= r_d2[s];
                r_ovf[s+1] <= r_ovf[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    assign o_tag = r_tag[QW];
    assign o_q   = r_q[QW];
    assign o_ovf = r_ovf[QW];
    assign o_neg = r_neg[QW];

endmodule

/* rtl/circumcenter_jacobian.sv */
// Circumcenter Jacobian: 2x2 derivative of the circumcenter of ri, rj, rk
// with respect to ri, all values signed Q16.16.
//
// Input channel: i_valid with the six coordinates; o_stall holds it off.
// Output channel: o_valid with the four entries, o_degenerate and
// o_saturated; the receiver holds a result by raising i_stall.
//
// A fully pipelined datapath: one triple per cycle while o_stall is low.
// Six stages form the differences, cross product, squared lengths, n and C^2,
// three form |p*n| and the rounding numerator, 34 run a restoring divider
// by 2*C^2 one quotient bit per stage, and one registers the saturated result.
//
// Collinear points give degenerate = 1 with zero entries. Entries that do not
// fit the signed 32-bit range clip and raise saturated.
// Reset (synchronous, active low) empties the pipeline.
// While a result waits under i_stall the whole pipeline holds and o_stall is
// high; it rises only then, so nothing is dropped or repeated.
`include "assert_macros.svh"

module circumcenter_jacobian (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [cj_pkg::CW-1:0] i_ri_x,
    input  logic signed [cj_pkg::CW-1:0] i_ri_y,
    input  logic signed [cj_pkg::CW-1:0] i_rj_x,
    input  logic signed [cj_pkg::CW-1:0] i_rj_y,
    input  logic signed [cj_pkg::CW-1:0] i_rk_x,
    input  logic signed [cj_pkg::CW-1:0] i_rk_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [cj_pkg::CW-1:0] o_dhx_drix,
    output logic signed [cj_pkg::CW-1:0] o_dhy_drix,
    output logic signed [cj_pkg::CW-1:0] o_dhx_driy,
    output logic signed [cj_pkg::CW-1:0] o_dhy_driy,
    output logic                         o_degenerate,
    output logic                         o_saturated
);

    localparam int CW  = cj_pkg::CW;
    localparam int QW  = cj_pkg::QW;
    localparam int NE  = cj_pkg::NE;

    logic w_en;

    cj_pkg::t_tag                  w_in_tag;
    cj_pkg::t_tag                  w_fr_tag;
    logic signed [cj_pkg::NSW-1:0] w_nx, w_ny;
    logic [cj_pkg::C2W-1:0]        w_c2;
    logic [cj_pkg::MW-1:0]         w_pm0, w_pm1;
    logic                          w_ps0, w_ps1;

    cj_pkg::t_tag                  w_pr_tag;
    logic [cj_pkg::NW-1:0]         w_num [NE];
    logic [cj_pkg::D2W-1:0]        w_d2;
    logic [NE-1:0]                 w_pr_neg;

    cj_pkg::t_tag                  w_dv_tag;
    logic [QW-1:0]                 w_q [NE];
    logic [NE-1:0]                 w_ovf;
    logic [NE-1:0]                 w_dv_neg;

    logic                          r_valid;
    logic [CW-1:0]                 r_ent [NE];
    logic                          r_degen;
    logic                          r_sat;
    logic [CW-1:0]                 n_ent [NE];
    logic                          n_sat;

    assign w_en     = !(r_valid && i_stall);
    assign o_stall  = !w_en;
    assign w_in_tag = '{valid: i_valid, degen: 1'b0};

    cj_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_in_tag),
        .i_ri_x  (i_ri_x),
        .i_ri_y  (i_ri_y),
        .i_rj_x  (i_rj_x),
        .i_rj_y  (i_rj_y),
        .i_rk_x  (i_rk_x),
        .i_rk_y  (i_rk_y),
        .o_tag   (w_fr_tag),
        .o_nx    (w_nx),
        .o_ny    (w_ny),
        .o_c2    (w_c2),
        .o_pm0   (w_pm0),
        .o_pm1   (w_pm1),
        .o_ps0   (w_ps0),
        .o_ps1   (w_ps1)
    );

    cj_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_fr_tag),
        .i_nx    (w_nx),
        .i_ny    (w_ny),
        .i_c2    (w_c2),
        .i_pm0   (w_pm0),
        .i_pm1   (w_pm1),
        .i_ps0   (w_ps0),
        .i_ps1   (w_ps1),
        .o_tag   (w_pr_tag),
        .o_num   (w_num),
        .o_d2    (w_d2),
        .o_neg   (w_pr_neg)
    );

    cj_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_pr_tag),
        .i_num   (w_num),
        .i_d2    (w_d2),
        .i_neg   (w_pr_neg),
        .o_tag   (w_dv_tag),
        .o_q     (w_q),
        .o_ovf   (w_ovf),
        .o_neg   (w_dv_neg)
    );

    always_comb begin
        logic          sat;
        logic [QW-1:0] mag;
        logic [QW-1:0] val;
        n_sat = 1'b0;
        for (int e = 0; e < NE; e++) begin
            if (w_dv_neg[e]) begin
                sat = w_ovf[e] || (w_q[e] > cj_pkg::LIM_Q);
                mag = sat ? cj_pkg::LIM_Q : w_q[e];
                val = ~mag + 1'b1;
            end else begin
                sat = w_ovf[e] || (w_q[e] >= cj_pkg::LIM_Q);
                mag = sat ? (cj_pkg::LIM_Q - 1'b1) : w_q[e];
                val = mag;
            end
            if (w_dv_tag.degen) begin
                n_ent[e] = '0;
            end else begin
                n_ent[e] = val[CW-1:0];
                n_sat    = n_sat | sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_dv_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ent   <= n_ent;
            r_degen <= w_dv_tag.degen;
            r_sat   <= n_sat;
        end
    end

    assign o_valid      = r_valid;
    assign o_dhx_drix   = $signed(r_ent[0]);
    assign o_dhy_drix   = $signed(r_ent[1]);
    assign o_dhx_driy   = $signed(r_ent[2]);
    assign o_dhy_driy   = $signed(r_ent[3]);
    assign o_degenerate = r_degen;
    assign o_saturated  = r_sat;

    `CJ_IMPLY(a_degen_zero, i_clk, i_rst_n, o_valid && o_degenerate, o_dhx_drix == 0 && o_dhy_drix == 0 && o_dhx_driy == 0 && o_dhy_driy == 0 && !o_saturated, "degenerate result with nonzero fields")
    `CJ_IMPLY(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input held off without a waiting result")
    `CJ_IMPLY(a_sat_clip, i_clk, i_rst_n, o_valid && o_saturated, o_dhx_drix[CW-2:0] == '1 || o_dhx_drix[CW-2:0] == '0 || o_dhy_drix[CW-2:0] == '1 || o_dhy_drix[CW-2:0] == '0 || o_dhx_driy[CW-2:0] == '1 || o_dhx_driy[CW-2:0] == '0 || o_dhy_driy[CW-2:0] == '1 || o_dhy_driy[CW-2:0] == '0, "saturated flag without a clipped entry")
    `CJ_IMPLY_NEXT(a_drain, i_clk, i_rst_n, o_valid && !i_stall && !w_dv_tag.valid, !o_valid, "result repeated after it was taken")

endmodule
